>>> rtl/vdt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex dedup table package
// Shared constants, codes and the token control word of the cell chain.
// ----------------------------------------------------------------------------
package vdt_pkg;

    localparam int CAPACITY_DEFAULT    = 256;
    localparam int COORD_WIDTH_DEFAULT = 32;
    localparam int FIELD_WIDTH         = 32;
    localparam int SLOT_WIDTH          = 8;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef struct packed {
        logic                  vld;
        logic                  op;
        logic                  found;
        logic                  stored;
        logic [SLOT_WIDTH-1:0] slot;
        logic [SLOT_WIDTH-1:0] read_slot;
    } token_ctl_t;

endpackage

>>> rtl/vdt_if.sv
// ----------------------------------------------------------------------------
// Vertex dedup table channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface vdt_req_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      op;
    logic signed [vdt_pkg::FIELD_WIDTH-1:0]    x_coord;
    logic signed [vdt_pkg::FIELD_WIDTH-1:0]    y_coord;
    logic signed [vdt_pkg::FIELD_WIDTH-1:0]    z_coord;
    logic        [vdt_pkg::SLOT_WIDTH-1:0]     read_index;

    modport source (output valid, output op, output x_coord, output y_coord,
                    output z_coord, output read_index, input ready);
    modport sink   (input valid, input op, input x_coord, input y_coord,
                    input z_coord, input read_index, output ready);
endinterface

interface vdt_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic        [vdt_pkg::SLOT_WIDTH-1:0]     result_index;
    logic                                      was_present;
    vdt_pkg::status_t                          status;
    logic signed [vdt_pkg::FIELD_WIDTH-1:0]    x_out;
    logic signed [vdt_pkg::FIELD_WIDTH-1:0]    y_out;
    logic signed [vdt_pkg::FIELD_WIDTH-1:0]    z_out;

    modport source (output valid, output result_index, output was_present,
                    output status, output x_out, output y_out, output z_out,
                    input ready);
    modport sink   (input valid, input result_index, input was_present,
                    input status, input x_out, input y_out, input z_out,
                    output ready);
endinterface

>>> rtl/vertex_dedup_table_top.sv
// ----------------------------------------------------------------------------
// Vertex dedup table
// A token per item walks the slot cells; appends absent vertices, reads slots.
// ----------------------------------------------------------------------------
// The token visits one cell per cycle along the slot chain, then passes the
//   tail register and the output register; one item at a time is in flight.
// A new request is taken while the previous response still waits.
// Reset clears the entry count and the token valids; stored vertices are
//   undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module vertex_dedup_table_top #(
    parameter int CAPACITY    = vdt_pkg::CAPACITY_DEFAULT,
    parameter int COORD_WIDTH = vdt_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    vdt_req_if.sink   request,
    vdt_rsp_if.source response
);

    localparam int CNT_WIDTH = $clog2(CAPACITY + 1);
    localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(CAPACITY);

    vdt_pkg::token_ctl_t      ctl_chain [CAPACITY+1];
    logic [COORD_WIDTH-1:0]   x_chain   [CAPACITY+1];
    logic [COORD_WIDTH-1:0]   y_chain   [CAPACITY+1];
    logic [COORD_WIDTH-1:0]   z_chain   [CAPACITY+1];

    vdt_pkg::token_ctl_t      head_ctl;
    logic                     busy_reg, busy_next;
    logic [CNT_WIDTH-1:0]     count_reg, count_next;
    logic                     tail_valid_reg, tail_valid_next;
    vdt_pkg::token_ctl_t      tail_ctl_reg;
    logic [COORD_WIDTH-1:0]   tail_x_reg, tail_y_reg, tail_z_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [vdt_pkg::SLOT_WIDTH-1:0]   out_index_reg, out_index_next;
    logic                     out_present_reg, out_present_next;
    vdt_pkg::status_t         out_status_reg, out_status_next;
    logic [vdt_pkg::FIELD_WIDTH-1:0]  out_x_reg, out_x_next;
    logic [vdt_pkg::FIELD_WIDTH-1:0]  out_y_reg, out_y_next;
    logic [vdt_pkg::FIELD_WIDTH-1:0]  out_z_reg, out_z_next;

    logic                     accept;
    logic                     tail_arrive;
    logic                     tail_move;

    assign request.ready = !busy_reg;
    assign accept        = request.valid && !busy_reg;
    assign tail_arrive   = ctl_chain[CAPACITY].vld;
    assign tail_move     = tail_valid_reg && (!out_valid_reg || response.ready);

    always_comb
    begin
        head_ctl           = '0;
        head_ctl.vld       = accept;
        head_ctl.op        = request.op;
        head_ctl.found     = 1'b0;
        head_ctl.stored    = 1'b0;
        head_ctl.slot      = '0;
        head_ctl.read_slot = request.read_index;
    end

    assign ctl_chain[0] = head_ctl;
    assign x_chain[0]   = request.x_coord[COORD_WIDTH-1:0];
    assign y_chain[0]   = request.y_coord[COORD_WIDTH-1:0];
    assign z_chain[0]   = request.z_coord[COORD_WIDTH-1:0];

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        vdt_cell #(
            .CAPACITY    (CAPACITY),
            .COORD_WIDTH (COORD_WIDTH),
            .CELL_INDEX  (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .count   (count_reg),
            .ctl_in  (ctl_chain[k]),
            .x_in    (x_chain[k]),
            .y_in    (y_chain[k]),
            .z_in    (z_chain[k]),
            .ctl_out (ctl_chain[k+1]),
            .x_out   (x_chain[k+1]),
            .y_out   (y_chain[k+1]),
            .z_out   (z_chain[k+1])
        );
    end

    always_comb
    begin
        busy_next       = busy_reg;
        count_next      = count_reg;
        tail_valid_next = tail_valid_reg;
        out_valid_next  = out_valid_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (tail_arrive)
        begin
            tail_valid_next = 1'b1;
            if (ctl_chain[CAPACITY].stored && (count_reg != FULL_COUNT))
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (out_valid_reg && response.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (tail_move)
        begin
            tail_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            busy_next       = 1'b0;
        end
    end

    always_comb
    begin
        out_index_next   = tail_ctl_reg.slot;
        out_present_next = 1'b0;
        out_status_next  = vdt_pkg::STATUS_OK;
        out_x_next       = '0;
        out_y_next       = '0;
        out_z_next       = '0;
        if (tail_ctl_reg.op == vdt_pkg::OP_ADD)
        begin
            if (tail_ctl_reg.found)
            begin
                out_present_next = 1'b1;
            end
            else if (!tail_ctl_reg.stored)
            begin
                out_status_next = vdt_pkg::STATUS_FULL;
                out_index_next  = '0;
            end
        end
        else
        begin
            out_index_next = tail_ctl_reg.read_slot;
            if (tail_ctl_reg.found)
            begin
                out_x_next = vdt_pkg::FIELD_WIDTH'($signed(tail_x_reg));
                out_y_next = vdt_pkg::FIELD_WIDTH'($signed(tail_y_reg));
                out_z_next = vdt_pkg::FIELD_WIDTH'($signed(tail_z_reg));
            end
            else
            begin
                out_status_next = vdt_pkg::STATUS_BAD_INDEX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            tail_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            tail_valid_reg <= tail_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_arrive)
        begin
            tail_ctl_reg <= ctl_chain[CAPACITY];
            tail_x_reg   <= x_chain[CAPACITY];
            tail_y_reg   <= y_chain[CAPACITY];
            tail_z_reg   <= z_chain[CAPACITY];
        end
        if (tail_move)
        begin
            out_index_reg   <= out_index_next;
            out_present_reg <= out_present_next;
            out_status_reg  <= out_status_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_z_reg       <= out_z_next;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.result_index = out_index_reg;
    assign response.was_present  = out_present_reg;
    assign response.status       = out_status_reg;
    assign response.x_out        = out_x_reg;
    assign response.y_out        = out_y_reg;
    assign response.z_out        = out_z_reg;

endmodule

>>> rtl/vdt_cell.sv
// ----------------------------------------------------------------------------
// Vertex dedup table cell
// Holds one table slot; compares, appends or reads as the token passes.
// ----------------------------------------------------------------------------
module vdt_cell #(
    parameter int CAPACITY    = vdt_pkg::CAPACITY_DEFAULT,
    parameter int COORD_WIDTH = vdt_pkg::COORD_WIDTH_DEFAULT,
    parameter int CELL_INDEX  = 0,
    localparam int CNT_WIDTH  = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [CNT_WIDTH-1:0]          count,
    input  vdt_pkg::token_ctl_t           ctl_in,
    input  logic [COORD_WIDTH-1:0]        x_in,
    input  logic [COORD_WIDTH-1:0]        y_in,
    input  logic [COORD_WIDTH-1:0]        z_in,
    output vdt_pkg::token_ctl_t           ctl_out,
    output logic [COORD_WIDTH-1:0]        x_out,
    output logic [COORD_WIDTH-1:0]        y_out,
    output logic [COORD_WIDTH-1:0]        z_out
);

    localparam logic [CNT_WIDTH-1:0] CELL_POS = CNT_WIDTH'(CELL_INDEX);
    localparam logic [vdt_pkg::SLOT_WIDTH-1:0] CELL_SLOT =
        vdt_pkg::SLOT_WIDTH'(CELL_INDEX);
    localparam bit SLOT_REACHABLE = CELL_INDEX < (1 << vdt_pkg::SLOT_WIDTH);

    vdt_pkg::token_ctl_t      ctl_reg, ctl_next;
    logic [COORD_WIDTH-1:0]   x_reg, x_next;
    logic [COORD_WIDTH-1:0]   y_reg, y_next;
    logic [COORD_WIDTH-1:0]   z_reg, z_next;
    logic [COORD_WIDTH-1:0]   store_x_reg;
    logic [COORD_WIDTH-1:0]   store_y_reg;
    logic [COORD_WIDTH-1:0]   store_z_reg;
    logic                     entry_live;
    logic                     coord_hit;
    logic                     slot_hit;
    logic                     write_en;

    assign entry_live = count > CELL_POS;
    assign coord_hit  = (store_x_reg == x_in) && (store_y_reg == y_in)
                        && (store_z_reg == z_in);
    assign slot_hit   = SLOT_REACHABLE && (ctl_in.read_slot == CELL_SLOT);

    always_comb
    begin
        ctl_next = ctl_in;
        x_next   = x_in;
        y_next   = y_in;
        z_next   = z_in;
        write_en = 1'b0;
        if (ctl_in.vld)
        begin
            if (ctl_in.op == vdt_pkg::OP_ADD)
            begin
                if (entry_live && !ctl_in.found && coord_hit)
                begin
                    ctl_next.found = 1'b1;
                    ctl_next.slot  = CELL_SLOT;
                end
                else if ((count == CELL_POS) && !ctl_in.found)
                begin
                    write_en        = 1'b1;
                    ctl_next.stored = 1'b1;
                    ctl_next.slot   = CELL_SLOT;
                end
            end
            else if (entry_live && slot_hit)
            begin
                ctl_next.found = 1'b1;
                x_next         = store_x_reg;
                y_next         = store_y_reg;
                z_next         = store_z_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (write_en)
        begin
            store_x_reg <= x_in;
            store_y_reg <= y_in;
            store_z_reg <= z_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule
